// ----- src/radio_api_frame_builder_defines.svh -----
// assertion macros shared by the frame builder modules
// no dependencies; taken in by include where checks are written
`ifndef RADIO_API_FRAME_BUILDER_DEFINES_SVH
`define RADIO_API_FRAME_BUILDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RAFB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("frame builder check failed");
`define RAFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame builder check failed");
`else
`define RAFB_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define RAFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/rafb_pkg.sv -----
// types and constants of the radio api frame builder
// no dependencies; used by every module of the block
package rafb_pkg;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_ERROR = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        expl_frame;
		logic [63:0] dest_address;
		logic [7:0]  data;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  frame_id;
		logic [7:0]  broadcast_radius;
		logic [7:0]  tx_options;
		logic [15:0] short_address;
	} cfg_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_DATA   = 4'b0010,
		PH_SUM    = 4'b0100,
		PH_ERROR  = 4'b1000
	} phase_t;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ID  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS    = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OPTIONS   = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_ADR = 8'd3;

	localparam logic       OP_START = 1'b0;

	localparam logic [4:0] HDR_DELIM      = 5'd0;
	localparam logic [4:0] HDR_LEN_HI     = 5'd1;
	localparam logic [4:0] HDR_LEN_LO     = 5'd2;
	localparam logic [4:0] HDR_TYPE       = 5'd3;
	localparam logic [4:0] HDR_FRAME_ID   = 5'd4;
	localparam logic [4:0] HDR_ADDR_FIRST = 5'd5;
	localparam logic [4:0] HDR_SHORT_HI   = 5'd13;
	localparam logic [4:0] HDR_SHORT_LO   = 5'd14;
	localparam logic [4:0] HDR_SRC_EP     = 5'd15;
	localparam logic [4:0] HDR_DST_EP     = 5'd16;
	localparam logic [4:0] HDR_CLUSTER_HI = 5'd17;
	localparam logic [4:0] HDR_CLUSTER_LO = 5'd18;
	localparam logic [4:0] HDR_PROFILE_HI = 5'd19;
	localparam logic [4:0] HDR_PROFILE_LO = 5'd20;
	localparam logic [4:0] HDR_RADIUS     = 5'd21;
	localparam logic [4:0] HDR_OPTIONS    = 5'd22;

	localparam logic [7:0]  DELIM_BYTE       = 8'h7E;
	localparam logic [7:0]  TYPE_TX          = 8'h10;
	localparam logic [7:0]  TYPE_EXPL        = 8'h11;
	localparam logic [15:0] LEN_TX           = 16'h000E;
	localparam logic [15:0] LEN_EXPL         = 16'h0014;
	localparam logic [7:0]  ENDPOINT_ID      = 8'hE8;
	localparam logic [15:0] CLUSTER_WORD     = 16'h0011;
	localparam logic [15:0] PROFILE_WORD     = 16'hC105;
	localparam logic [7:0]  SUM_BASE         = 8'hFF;
	localparam logic [15:0] SHORT_ADR_RESET  = 16'hFFFE;

endpackage

// ----- src/rafb_front.sv -----
// front end: accepts items, tracks the open frame and classifies each beat
// depends on rafb_pkg; feeds rafb_queue
`include "radio_api_frame_builder_defines.svh"
module rafb_front #(
	parameter int unsigned MAX_PAYLOAD = 255
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  logic          operation,
	input  logic          frame_type,
	input  logic [63:0]   dest_address,
	input  logic [7:0]    payload_length,
	input  logic [7:0]    payload_byte,
	output logic          push,
	output rafb_pkg::cmd_t push_cmd,
	input  logic          queue_full
);
	import rafb_pkg::*;

	logic       frame_open_q;
	logic [7:0] bytes_left_q;
	logic [7:0] length_c;
	logic       take;

	assign item_stall = queue_full;
	assign take       = item_valid && !item_stall;
	assign push       = take;

	always_comb begin
		length_c = payload_length;
		if (32'(payload_length) > MAX_PAYLOAD) begin
			length_c = 8'(MAX_PAYLOAD);
		end
		push_cmd.expl_frame   = frame_type;
		push_cmd.dest_address = dest_address;
		if (operation == OP_START) begin
			push_cmd.kind = CMD_START;
			push_cmd.data = length_c;
			push_cmd.last = (length_c == 8'd0);
		end else if (frame_open_q) begin
			push_cmd.kind = CMD_DATA;
			push_cmd.data = payload_byte;
			push_cmd.last = (bytes_left_q == 8'd1);
		end else begin
			push_cmd.kind = CMD_ERROR;
			push_cmd.data = 8'd0;
			push_cmd.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= 8'd0;
		end else if (take) begin
			if (operation == OP_START) begin
				frame_open_q <= (length_c != 8'd0);
				bytes_left_q <= length_c;
			end else if (frame_open_q) begin
				bytes_left_q <= bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

	`RAFB_ASSERT_IMPL(a_open_has_bytes, clk, arst_n, frame_open_q, bytes_left_q != 8'd0)

endmodule

// ----- src/rafb_queue.sv -----
// short command queue between the front and back ends
// depends on rafb_pkg
`include "radio_api_frame_builder_defines.svh"
module rafb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rafb_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output rafb_pkg::cmd_t head_cmd
);
	import rafb_pkg::*;

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`RAFB_ASSERT_IMPL(a_pop_not_empty, clk, arst_n, pop, head_valid)

endmodule

// ----- src/rafb_back.sv -----
// back end: serializes header, payload, checksum and error beats into the output register
// depends on rafb_pkg; reads the head of rafb_queue
`include "radio_api_frame_builder_defines.svh"
module rafb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rafb_pkg::cfg_t cfg,
	input  logic           head_valid,
	input  rafb_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           result_valid,
	input  logic           result_stall,
	output logic [7:0]     out_byte,
	output logic           frame_end,
	output logic           run_end,
	output logic           error
);
	import rafb_pkg::*;

	phase_t      phase_q;
	logic [4:0]  idx_q;
	logic        mid_q;
	logic [7:0]  sum_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        fend_q;
	logic        rend_q;
	logic        err_q;

	phase_t      phase_c;
	phase_t      phase_n;
	logic [4:0]  idx_c;
	logic [4:0]  idx_n;
	logic [15:0] len_c;
	logic [2:0]  addr_pos;
	logic [7:0]  byte_c;
	logic        add_c;
	logic        clear_c;
	logic        done_c;
	logic        fend_c;
	logic        err_c;
	logic        fire;

	assign fire = head_valid && (!valid_q || !result_stall);
	assign pop  = fire && done_c;

	always_comb begin
		if (mid_q) begin
			phase_c = phase_q;
			idx_c   = idx_q;
		end else begin
			idx_c = HDR_DELIM;
			unique case (head_cmd.kind)
				CMD_START: phase_c = PH_HEADER;
				CMD_DATA:  phase_c = PH_DATA;
				default:   phase_c = PH_ERROR;
			endcase
		end
		len_c    = (head_cmd.expl_frame ? LEN_EXPL : LEN_TX) + {8'h00, head_cmd.data};
		addr_pos = 3'(idx_c - HDR_ADDR_FIRST);
		byte_c   = 8'h00;
		add_c    = 1'b0;
		clear_c  = 1'b0;
		done_c   = 1'b0;
		fend_c   = 1'b0;
		err_c    = 1'b0;
		phase_n  = phase_c;
		idx_n    = idx_c + 5'd1;
		unique case (phase_c)
			PH_HEADER: begin
				add_c = (idx_c >= HDR_TYPE);
				unique case (idx_c)
					HDR_DELIM: begin
						byte_c  = DELIM_BYTE;
						clear_c = 1'b1;
					end
					HDR_LEN_HI:     byte_c = len_c[15:8];
					HDR_LEN_LO:     byte_c = len_c[7:0];
					HDR_TYPE:       byte_c = head_cmd.expl_frame ? TYPE_EXPL : TYPE_TX;
					HDR_FRAME_ID:   byte_c = cfg.frame_id;
					HDR_SHORT_HI:   byte_c = cfg.short_address[15:8];
					HDR_SHORT_LO: begin
						byte_c = cfg.short_address[7:0];
						if (!head_cmd.expl_frame) begin
							idx_n = HDR_RADIUS;
						end
					end
					HDR_SRC_EP:     byte_c = ENDPOINT_ID;
					HDR_DST_EP:     byte_c = ENDPOINT_ID;
					HDR_CLUSTER_HI: byte_c = CLUSTER_WORD[15:8];
					HDR_CLUSTER_LO: byte_c = CLUSTER_WORD[7:0];
					HDR_PROFILE_HI: byte_c = PROFILE_WORD[15:8];
					HDR_PROFILE_LO: byte_c = PROFILE_WORD[7:0];
					HDR_RADIUS:     byte_c = cfg.broadcast_radius;
					HDR_OPTIONS: begin
						byte_c = cfg.tx_options;
						if (head_cmd.last) begin
							phase_n = PH_SUM;
						end else begin
							done_c = 1'b1;
						end
					end
					default:        byte_c = head_cmd.dest_address[{~addr_pos, 3'b000} +: 8];
				endcase
			end
			PH_DATA: begin
				byte_c = head_cmd.data;
				add_c  = 1'b1;
				if (head_cmd.last) begin
					phase_n = PH_SUM;
				end else begin
					done_c = 1'b1;
				end
			end
			PH_SUM: begin
				byte_c = SUM_BASE - sum_q;
				fend_c = 1'b1;
				done_c = 1'b1;
			end
			default: begin
				err_c  = 1'b1;
				done_c = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= HDR_DELIM;
			mid_q   <= 1'b0;
			sum_q   <= 8'd0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_q <= 1'b1;
				mid_q   <= !done_c;
				phase_q <= phase_n;
				idx_q   <= idx_n;
				if (clear_c) begin
					sum_q <= 8'd0;
				end else if (add_c) begin
					sum_q <= sum_q + byte_c;
				end
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= byte_c;
			fend_q <= fend_c;
			rend_q <= done_c;
			err_q  <= err_c;
		end
	end

	assign result_valid = valid_q;
	assign out_byte     = byte_q;
	assign frame_end    = fend_q;
	assign run_end      = rend_q;
	assign error        = err_q;

	`RAFB_ASSERT_IMPL(a_mid_needs_head, clk, arst_n, mid_q, head_valid)
	`RAFB_ASSERT_IMPL(a_err_result, clk, arst_n, valid_q && err_q, rend_q && byte_q == 8'h00)
	`RAFB_ASSERT_IMPL(a_fend_closes, clk, arst_n, valid_q && fend_q, rend_q && !err_q)

endmodule

// ----- src/radio_api_frame_builder.sv -----
// radio api transmit frame builder top level: config registers and the
// front end, command queue and back end; depends on rafb_pkg and the rafb modules
//
// items enter on item_valid/item_stall, one beat per cycle while the command
// queue has room. a start beat yields the frame header (17 bytes, or 23 for
// explicit addressing) plus the checksum when the length is zero; a payload
// beat yields its byte, plus the checksum on the last one, or one error beat
// when no frame is open. result beats leave on result_valid/result_stall at
// one per cycle while result_stall is low; the back end produces one byte per
// cycle while not stalled, so header bytes set the pace and payload beats pass
// back to back. an item taken is written into the command queue, and its first
// result beat is then registered in the output register. a stalled result holds;
// the back end waits and the four-entry queue fills before item_stall rises.
// registers are written on cfg_valid/cfg_ready, always ready; indexes above
// three are ignored. reset empties the queue, closes any open frame and sets
// the registers to frame id 0, radius 0, options 0 and short address fffe.
`include "radio_api_frame_builder_defines.svh"
module radio_api_frame_builder #(
	parameter int unsigned MAX_PAYLOAD = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        operation,
	input  logic        frame_type,
	input  logic [63:0] dest_address,
	input  logic [7:0]  payload_length,
	input  logic [7:0]  payload_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        run_end,
	output logic        error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [rafb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import rafb_pkg::*;

	cfg_t cfg_q;
	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic queue_full;
	logic head_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_id         <= 8'd0;
			cfg_q.broadcast_radius <= 8'd0;
			cfg_q.tx_options       <= 8'd0;
			cfg_q.short_address    <= SHORT_ADR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_ID:  cfg_q.frame_id         <= cfg_data[7:0];
				REG_RADIUS:    cfg_q.broadcast_radius <= cfg_data[7:0];
				REG_OPTIONS:   cfg_q.tx_options       <= cfg_data[7:0];
				REG_SHORT_ADR: cfg_q.short_address    <= cfg_data;
				default: ;
			endcase
		end
	end

	rafb_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.operation     (operation),
		.frame_type    (frame_type),
		.dest_address  (dest_address),
		.payload_length(payload_length),
		.payload_byte  (payload_byte),
		.push          (push),
		.push_cmd      (push_cmd),
		.queue_full    (queue_full)
	);

	rafb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	rafb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte    (out_byte),
		.frame_end   (frame_end),
		.run_end     (run_end),
		.error       (error)
	);

	`RAFB_ASSERT_IMPL(a_push_has_room, clk, arst_n, push, !queue_full)

endmodule

// ----- bench/radio_api_frame_builder_tb.sv -----
`timescale 1ns / 100ps
// bench for radio_api_frame_builder: directed and random frames, a scoreboard
// that predicts every output beat; depends on rafb_pkg and the block's rtl
module radio_api_frame_builder_tb;
	import rafb_pkg::*;

	localparam logic OP_PAYLOAD    = 1'b1;
	localparam logic FT_TX         = 1'b0;
	localparam logic FT_EXPL       = 1'b1;
	localparam int   QUIET_LIMIT   = 4000;
	localparam int   SETTLE_CYCLES = 12;
	localparam int   HOLD_CYCLES   = 90;
	localparam int   MAX_REPORTS   = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       frame_end;
		logic       run_end;
		logic       error;
	} link_beat_t;

	class frame_scoreboard;
		link_beat_t  expected_q[$];
		link_beat_t  held;
		bit          have_held;
		logic [7:0]  frame_id, radius, options;
		logic [15:0] short_adr;
		logic [7:0]  bytes_left, sum;
		bit          open;
		int          mismatches;

		function new();
			frame_id   = 8'h00;
			radius     = 8'h00;
			options    = 8'h00;
			short_adr  = SHORT_ADR_RESET;
			bytes_left = 8'h00;
			sum        = 8'h00;
			open       = 1'b0;
			have_held  = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
			case (idx)
				REG_FRAME_ID:  frame_id = value[7:0];
				REG_RADIUS:    radius = value[7:0];
				REG_OPTIONS:   options = value[7:0];
				REG_SHORT_ADR: short_adr = value;
				default: ;
			endcase
		endfunction

		// the last beat of an item is held back so run_end can be set on it
		function void emit(logic [7:0] data, logic fend, logic err);
			if (have_held)
				expected_q.push_back(held);
			held.data      = data;
			held.frame_end = fend;
			held.run_end   = 1'b0;
			held.error     = err;
			have_held      = 1'b1;
		endfunction

		function void emit_summed(logic [7:0] data);
			sum = sum + data;
			emit(data, 1'b0, 1'b0);
		endfunction

		function void close_frame();
			emit(SUM_BASE - sum, 1'b1, 1'b0);
			open       = 1'b0;
			bytes_left = 8'h00;
			sum        = 8'h00;
		endfunction

		function void note_item(logic op, logic ftype, logic [63:0] addr, logic [7:0] len,
				logic [7:0] pb);
			logic [15:0] flen;
			if (op == OP_START) begin
				flen = ((ftype == FT_EXPL) ? LEN_EXPL : LEN_TX) + {8'h00, len};
				sum  = 8'h00;
				emit(DELIM_BYTE, 1'b0, 1'b0);
				emit(flen[15:8], 1'b0, 1'b0);
				emit(flen[7:0], 1'b0, 1'b0);
				emit_summed((ftype == FT_EXPL) ? TYPE_EXPL : TYPE_TX);
				emit_summed(frame_id);
				for (int i = 7; i >= 0; i--)
					emit_summed(addr[8*i +: 8]);
				emit_summed(short_adr[15:8]);
				emit_summed(short_adr[7:0]);
				if (ftype == FT_EXPL) begin
					emit_summed(ENDPOINT_ID);
					emit_summed(ENDPOINT_ID);
					emit_summed(CLUSTER_WORD[15:8]);
					emit_summed(CLUSTER_WORD[7:0]);
					emit_summed(PROFILE_WORD[15:8]);
					emit_summed(PROFILE_WORD[7:0]);
				end
				emit_summed(radius);
				emit_summed(options);
				open       = 1'b1;
				bytes_left = len;
				if (len == 8'h00)
					close_frame();
			end else if (!open) begin
				emit(8'h00, 1'b0, 1'b1);
			end else begin
				emit_summed(pb);
				bytes_left = bytes_left - 8'h01;
				if (bytes_left == 8'h00)
					close_frame();
			end
			held.run_end = 1'b1;
			expected_q.push_back(held);
			have_held = 1'b0;
		endfunction

		function void check_result(link_beat_t got);
			link_beat_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected beat: byte %h frame_end %b run_end %b error %b",
						got.data, got.frame_end, got.run_end, got.error);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("expected %h fe %b re %b err %b, got %h fe %b re %b err %b",
							want.data, want.frame_end, want.run_end, want.error,
							got.data, got.frame_end, got.run_end, got.error);
				end
			end
		endfunction
	endclass

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        item_valid     = 1'b0;
	logic        item_stall;
	logic        operation      = OP_START;
	logic        frame_type     = FT_TX;
	logic [63:0] dest_address   = 64'h0;
	logic [7:0]  payload_length = 8'h00;
	logic [7:0]  payload_byte   = 8'h00;
	logic        result_valid;
	logic        result_stall   = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_end;
	logic        run_end;
	logic        error;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_ID;
	logic [15:0] cfg_data       = 16'h0000;

	frame_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_request  = 1'b0;
	int hold_left     = 0;
	int quiet         = 0;

	radio_api_frame_builder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.operation      (operation),
		.frame_type     (frame_type),
		.dest_address   (dest_address),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_byte       (out_byte),
		.frame_end      (frame_end),
		.run_end        (run_end),
		.error          (error),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result({out_byte, frame_end, run_end, error});
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL radio_api_frame_builder");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_item(input logic op, input logic ftype, input logic [63:0] addr,
			input logic [7:0] len, input logic [7:0] pb);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid     <= 1'b1;
		operation      <= op;
		frame_type     <= ftype;
		dest_address   <= addr;
		payload_length <= len;
		payload_byte   <= pb;
		do @(posedge clk); while (item_stall);
		sb.note_item(op, ftype, addr, len, pb);
	endtask

	task automatic send_start(input logic ftype, input logic [7:0] len, input logic [63:0] addr);
		send_item(OP_START, ftype, addr, len, 8'($urandom_range(255)));
	endtask

	task automatic send_payload(input logic [7:0] pb);
		send_item(OP_PAYLOAD, 1'($urandom_range(1)), rand64(), 8'($urandom_range(255)), pb);
	endtask

	// mostly well-formed frames, some cut short by a new start, some stray payload
	task automatic run_traffic(input int count);
		int sent, n, m, r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 8) begin
				send_payload(8'($urandom_range(255)));
				sent++;
			end else begin
				r = $urandom_range(99);
				if (r < 70)
					n = $urandom_range(6);
				else if (r < 90)
					n = $urandom_range(20, 7);
				else if (r < 95)
					n = $urandom_range(254, 21);
				else
					n = 255;
				m = n;
				if (n > 20 || (n > 0 && $urandom_range(99) < 15))
					m = $urandom_range((n > 12) ? 12 : n - 1);
				send_start(1'($urandom_range(1)), 8'(n), rand64());
				sent++;
				repeat (m) begin
					send_payload(8'($urandom_range(255)));
					sent++;
				end
			end
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] fid, input logic [7:0] rad,
			input logic [7:0] opt, input logic [15:0] sadr);
		write_reg(REG_FRAME_ID, {8'($urandom_range(255)), fid});
		write_reg(REG_RADIUS, {8'($urandom_range(255)), rad});
		write_reg(REG_OPTIONS, {8'($urandom_range(255)), opt});
		write_reg(REG_SHORT_ADR, sadr);
		// an index past the last register must change nothing
		write_reg(REG_SHORT_ADR + 8'($urandom_range(252, 1)), 16'($urandom_range(65535)));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats on the reset register values
		send_payload(8'h5A);
		send_start(FT_TX, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_start(FT_EXPL, 8'd0, 64'h0);
		send_start(FT_TX, 8'd2, 64'h0123_4567_89AB_CDEF);
		send_payload(8'h00);
		send_payload(8'hFF);
		send_start(FT_EXPL, 8'd1, rand64());
		send_payload(8'hA5);
		send_start(FT_TX, 8'd255, rand64());
		send_payload(8'h3C);
		send_payload(8'hC3);
		send_start(FT_EXPL, 8'd3, rand64());
		send_payload(8'h01);
		send_payload(8'h80);
		send_payload(8'h7F);
		send_payload(8'hFE);
		send_start(FT_EXPL, 8'd1, rand64());
		send_start(FT_TX, 8'd0, rand64());
		drain();

		configure(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		hold_request = 1'b1;
		run_traffic(46);
		drain();

		send_idle_pct = 56;
		configure(8'h00, 8'h00, 8'h00, 16'h0000);
		run_traffic(46);
		drain();

		send_idle_pct = 0;
		stall_pct     = 56;
		configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(65535)));
		run_traffic(46);
		drain();

		send_idle_pct = 34;
		stall_pct     = 34;
		configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(65535)));
		run_traffic(46);
		drain();

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("PASS radio_api_frame_builder");
		else
			$display("FAIL radio_api_frame_builder");
		$finish;
	end
endmodule
